[src/h264fua_pkg.sv]
// Package with the types, codes and constants shared by the FU-A depacketizer modules.
`timescale 1ns / 1ps
package h264fua_pkg;

  // Default store sizes.
  localparam int PKT_PAYLOAD_BYTES_DEF = 2048;
  localparam int NALU_BYTES_DEF        = 16384;

  // RTP and H.264 framing constants.
  localparam int          OFF_W         = 16;
  localparam int          RTP_HDR_BYTES = 12;
  localparam logic [7:0]  FU_A_TYPE     = 8'd28;
  localparam logic [7:0]  TYPE_MASK     = 8'h1F;
  localparam logic [7:0]  F_NRI_MASK    = 8'hE0;
  localparam int          S_BIT         = 7;
  localparam int          E_BIT         = 6;
  localparam logic [7:0]  ANNEXB_PREFIX [4] = '{8'h00, 8'h00, 8'h00, 8'h01};

  // Input commands.
  typedef enum logic [1:0] {
    CMD_PACKET = 2'd0,
    CMD_READ   = 2'd1,
    CMD_FLUSH  = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  // Result status codes.
  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_OVERRUN = 3'd1,
    ST_EMPTY   = 3'd2,
    ST_DROPPED = 3'd3,
    ST_TRUNC   = 3'd4
  } status_t;

  // Which store holds the NALU that waits to be read.
  typedef enum logic [1:0] {
    PEND_NONE   = 2'd0,
    PEND_SINGLE = 2'd1,
    PEND_REASM  = 2'd2
  } pend_src_t;

  // One result item as it leaves the engine.
  typedef struct packed {
    status_t    status;
    logic [7:0] byte_val;
    logic       byte_vld;
    logic       nalu_last;
    logic       pending;
  } result_t;

endpackage

[src/h264_fu_a_depacketizer.sv]
// Top level of the H.264 RTP FU-A depacketizer with its handshake and output register.
//
//   Channel | Direction | Transfer when         | Payload
//   --------+-----------+-----------------------+------------------------------------------
//   in_     | input     | in_valid && !in_stall | in_command, in_data_byte, in_packet_end
//   out_    | output    | out_valid && !out_stall | out_status, out_byte, out_out_valid,
//           |           |                       |   out_nalu_last, out_nalu_pending
//
// One input transfer per cycle is sustained while the output is not stalled; each transfer yields exactly one result.
// Each result passes through the store read in the engine, then the output register.
// Each item makes at most one access to one store, which lets that input rate be sustained.
// Reset is synchronous and active low; the stores need no clearing pass.
// in_stall rises only when the read stage is full and the output register is stalled.
`timescale 1ns / 1ps
module h264_fu_a_depacketizer #(
  parameter int PACKET_PAYLOAD_BYTES = h264fua_pkg::PKT_PAYLOAD_BYTES_DEF,
  parameter int NALU_BYTES           = h264fua_pkg::NALU_BYTES_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_command,
  input  logic [7:0] in_data_byte,
  input  logic       in_packet_end,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [2:0] out_status,
  output logic [7:0] out_byte,
  output logic       out_out_valid,
  output logic       out_nalu_last,
  output logic       out_nalu_pending
);
  import h264fua_pkg::*;

  logic    in_xfer;
  logic    o_ready;
  logic    s1_valid_r, s1_valid_nxt;
  logic    out_valid_r, out_valid_nxt;
  result_t res;
  result_t out_res_r;

  // Handshake: the read stage moves on whenever the output register can take it.
  assign o_ready  = !out_valid_r || !out_stall;
  assign in_stall = s1_valid_r && !o_ready;
  assign in_xfer  = in_valid && !in_stall;

  h264fua_engine #(
    .PACKET_PAYLOAD_BYTES(PACKET_PAYLOAD_BYTES),
    .NALU_BYTES          (NALU_BYTES)
  ) u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .item_en   (in_xfer),
    .command   (cmd_t'(in_command)),
    .data_byte (in_data_byte),
    .packet_end(in_packet_end),
    .res       (res)
  );

  // Occupancy of the read stage and the output register.
  always_comb begin
    s1_valid_nxt  = s1_valid_r;
    out_valid_nxt = out_valid_r;
    if (o_ready) begin
      out_valid_nxt = s1_valid_r;
      s1_valid_nxt  = 1'b0;
    end
    if (in_xfer) begin
      s1_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Output payload register.
  always_ff @(posedge clk) begin
    if (s1_valid_r && o_ready) begin
      out_res_r <= res;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_res_r.status;
  assign out_byte         = out_res_r.byte_val;
  assign out_out_valid    = out_res_r.byte_vld;
  assign out_nalu_last    = out_res_r.nalu_last;
  assign out_nalu_pending = out_res_r.pending;

  // An accepted item always occupies the read stage next cycle.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> s1_valid_r)
    else $error("accepted item missing from the read stage");

  // A blocked read stage keeps its result, store read data included.
  assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !o_ready) |=> (s1_valid_r && $stable(res)))
    else $error("blocked read stage lost its result");

  // Input is held back only when both stages are full.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && out_valid_r))
    else $error("input stalled with room in the pipeline");

endmodule

[src/h264fua_engine.sv]
// Depacketizer engine: control state, the two byte stores and result assembly.
`timescale 1ns / 1ps
module h264fua_engine #(
  parameter int PACKET_PAYLOAD_BYTES = h264fua_pkg::PKT_PAYLOAD_BYTES_DEF,
  parameter int NALU_BYTES           = h264fua_pkg::NALU_BYTES_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 item_en,
  input  h264fua_pkg::cmd_t    command,
  input  logic [7:0]           data_byte,
  input  logic                 packet_end,
  output h264fua_pkg::result_t res
);
  import h264fua_pkg::*;

  localparam int MAX_BYTES = (PACKET_PAYLOAD_BYTES > NALU_BYTES) ?
                             PACKET_PAYLOAD_BYTES : NALU_BYTES;
  localparam int SA_W  = $clog2(PACKET_PAYLOAD_BYTES);
  localparam int RA_W  = $clog2(NALU_BYTES);
  localparam int SL_W  = $clog2(PACKET_PAYLOAD_BYTES + 1);
  localparam int RL_W  = $clog2(NALU_BYTES + 1);
  localparam int CNT_W = $clog2(MAX_BYTES + 5);

  // Byte stores.
  logic [7:0] single_mem [PACKET_PAYLOAD_BYTES];
  logic [7:0] reasm_mem  [NALU_BYTES];

  // Control state.
  logic [OFF_W-1:0] off_r, off_nxt;
  logic             spoil_r, spoil_nxt;
  logic [7:0]       ind_r, ind_nxt;
  logic [7:0]       fh_r, fh_nxt;
  logic [SL_W-1:0]  slen_r, slen_nxt;
  logic [RL_W-1:0]  rlen_r, rlen_nxt;
  pend_src_t        pend_r, pend_nxt;
  logic [CNT_W-1:0] idx_r, idx_nxt;

  // Result fields carried alongside the store read.
  status_t    m_status_r, m_status_nxt;
  logic [7:0] m_code_r, m_code_nxt;
  logic       m_mem_r, m_mem_nxt;
  logic       m_reasm_r, m_reasm_nxt;
  logic       m_vld_r, m_vld_nxt;
  logic       m_last_r, m_last_nxt;
  logic       m_pend_r, m_pend_nxt;

  // Store ports.
  logic            s_we, s_re, r_we, r_re;
  logic [SA_W-1:0] s_addr;
  logic [RA_W-1:0] r_addr;
  logic [7:0]      s_wdata, r_wdata;
  logic [7:0]      s_rdata_r, r_rdata_r;

  logic [CNT_W-1:0] len_sel;
  logic [CNT_W-1:0] mem_idx;
  logic             read_last;

  // Read position helpers for the NALU being streamed out.
  assign len_sel   = (pend_r == PEND_REASM) ? CNT_W'(rlen_r) : CNT_W'(slen_r);
  assign mem_idx   = idx_r - CNT_W'(4);
  assign read_last = (idx_r + CNT_W'(1)) >= (CNT_W'(4) + len_sel);

  // Next state and store accesses for one accepted item.
  always_comb begin
    off_nxt      = off_r;
    spoil_nxt    = spoil_r;
    ind_nxt      = ind_r;
    fh_nxt       = fh_r;
    slen_nxt     = slen_r;
    rlen_nxt     = rlen_r;
    pend_nxt     = pend_r;
    idx_nxt      = idx_r;
    m_status_nxt = ST_OK;
    m_code_nxt   = 8'h00;
    m_mem_nxt    = 1'b0;
    m_reasm_nxt  = 1'b0;
    m_vld_nxt    = 1'b0;
    m_last_nxt   = 1'b0;
    s_we         = 1'b0;
    s_re         = 1'b0;
    r_we         = 1'b0;
    r_re         = 1'b0;
    s_addr       = '0;
    r_addr       = '0;
    s_wdata      = data_byte;
    r_wdata      = data_byte;
    if (item_en) begin
      case (command)
        CMD_PACKET: begin
          if (spoil_r || (pend_r != PEND_NONE)) begin
            // A NALU still waits, or the packet is already spoiled: the whole packet is lost.
            spoil_nxt    = 1'b1;
            m_status_nxt = ST_OVERRUN;
          end else if (off_r >= OFF_W'(RTP_HDR_BYTES)) begin
            if (off_r == OFF_W'(RTP_HDR_BYTES)) begin
              // First payload byte: NAL header or FU indicator.
              ind_nxt = data_byte;
              if ((data_byte & TYPE_MASK) != FU_A_TYPE) begin
                s_we     = 1'b1;
                slen_nxt = SL_W'(1);
              end
            end else if ((ind_r & TYPE_MASK) != FU_A_TYPE) begin
              if (slen_r < SL_W'(PACKET_PAYLOAD_BYTES)) begin
                s_we     = 1'b1;
                s_addr   = slen_r[SA_W-1:0];
                slen_nxt = slen_r + SL_W'(1);
              end else begin
                m_status_nxt = ST_TRUNC;
              end
            end else if (off_r == OFF_W'(RTP_HDR_BYTES + 1)) begin
              // Fragment header; a start fragment rebuilds the NAL header.
              fh_nxt = data_byte;
              if (data_byte[S_BIT]) begin
                r_we     = 1'b1;
                r_wdata  = (ind_r & F_NRI_MASK) | (data_byte & TYPE_MASK);
                rlen_nxt = RL_W'(1);
              end
            end else if (rlen_r != '0) begin
              if (rlen_r < RL_W'(NALU_BYTES)) begin
                r_we     = 1'b1;
                r_addr   = rlen_r[RA_W-1:0];
                rlen_nxt = rlen_r + RL_W'(1);
              end else begin
                m_status_nxt = ST_TRUNC;
              end
            end
          end
          if (off_r != {OFF_W{1'b1}}) begin
            off_nxt = off_r + OFF_W'(1);
          end
          // Packet close: drop a packet with at most one payload byte, else complete a NALU where the packet allows it.
          if (packet_end) begin
            if (!spoil_nxt) begin
              if (off_r <= OFF_W'(RTP_HDR_BYTES)) begin
                m_status_nxt = ST_DROPPED;
              end else if ((ind_nxt & TYPE_MASK) != FU_A_TYPE) begin
                pend_nxt = PEND_SINGLE;
                idx_nxt  = '0;
              end else if (!fh_nxt[S_BIT] && fh_nxt[E_BIT] && (rlen_nxt != '0)) begin
                pend_nxt = PEND_REASM;
                idx_nxt  = '0;
              end
            end
            off_nxt   = '0;
            spoil_nxt = 1'b0;
          end
        end
        CMD_READ: begin
          if (pend_r == PEND_NONE) begin
            m_status_nxt = ST_EMPTY;
          end else begin
            m_vld_nxt   = 1'b1;
            m_reasm_nxt = (pend_r == PEND_REASM);
            if (idx_r < CNT_W'(4)) begin
              m_code_nxt = ANNEXB_PREFIX[idx_r[1:0]];
            end else begin
              m_mem_nxt = 1'b1;
              if (pend_r == PEND_REASM) begin
                r_re   = 1'b1;
                r_addr = mem_idx[RA_W-1:0];
              end else begin
                s_re   = 1'b1;
                s_addr = mem_idx[SA_W-1:0];
              end
            end
            if (read_last) begin
              m_last_nxt = 1'b1;
              if (pend_r == PEND_REASM) begin
                rlen_nxt = '0;
              end else begin
                slen_nxt = '0;
              end
              pend_nxt = PEND_NONE;
              idx_nxt  = '0;
            end else begin
              idx_nxt = idx_r + CNT_W'(1);
            end
          end
        end
        CMD_FLUSH: begin
          if (pend_r != PEND_NONE) begin
            m_status_nxt = ST_OVERRUN;
          end else if (rlen_r == '0) begin
            m_status_nxt = ST_EMPTY;
          end else begin
            pend_nxt = PEND_REASM;
            idx_nxt  = '0;
          end
        end
        default: begin
        end
      endcase
    end
    m_pend_nxt = (pend_nxt != PEND_NONE);
  end

  // Control state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      off_r   <= '0;
      spoil_r <= 1'b0;
      ind_r   <= '0;
      fh_r    <= '0;
      slen_r  <= '0;
      rlen_r  <= '0;
      pend_r  <= PEND_NONE;
      idx_r   <= '0;
    end else begin
      off_r   <= off_nxt;
      spoil_r <= spoil_nxt;
      ind_r   <= ind_nxt;
      fh_r    <= fh_nxt;
      slen_r  <= slen_nxt;
      rlen_r  <= rlen_nxt;
      pend_r  <= pend_nxt;
      idx_r   <= idx_nxt;
    end
  end

  // Result fields, held until the next accepted item.
  always_ff @(posedge clk) begin
    if (item_en) begin
      m_status_r <= m_status_nxt;
      m_code_r   <= m_code_nxt;
      m_mem_r    <= m_mem_nxt;
      m_reasm_r  <= m_reasm_nxt;
      m_vld_r    <= m_vld_nxt;
      m_last_r   <= m_last_nxt;
      m_pend_r   <= m_pend_nxt;
    end
  end

  // Single NALU store, one access per cycle; read data holds between reads.
  always_ff @(posedge clk) begin
    if (s_we) begin
      single_mem[s_addr] <= s_wdata;
    end
    if (s_re) begin
      s_rdata_r <= single_mem[s_addr];
    end
  end

  // Reassembly store, one access per cycle; read data holds between reads.
  always_ff @(posedge clk) begin
    if (r_we) begin
      reasm_mem[r_addr] <= r_wdata;
    end
    if (r_re) begin
      r_rdata_r <= reasm_mem[r_addr];
    end
  end

  // Result assembly from the held fields and the store read data.
  always_comb begin
    res.status    = m_status_r;
    res.byte_val  = m_mem_r ? (m_reasm_r ? r_rdata_r : s_rdata_r) : m_code_r;
    res.byte_vld  = m_vld_r;
    res.nalu_last = m_last_r;
    res.pending   = m_pend_r;
  end

  // Stores are only written while no NALU is pending.
  assert property (@(posedge clk) disable iff (!rst_n)
    (s_we || r_we) |-> (pend_r == PEND_NONE))
    else $error("store write while a NALU is pending");

  // A pending NALU always has at least one byte.
  assert property (@(posedge clk) disable iff (!rst_n)
    ((pend_r == PEND_REASM) |-> (rlen_r != '0)) and
    ((pend_r == PEND_SINGLE) |-> (slen_r != '0)))
    else $error("pending NALU with zero length");

  // Fill levels never pass the store sizes.
  assert property (@(posedge clk) disable iff (!rst_n)
    (slen_r <= SL_W'(PACKET_PAYLOAD_BYTES)) && (rlen_r <= RL_W'(NALU_BYTES)))
    else $error("store length beyond its size");

  // The final read byte releases the pending NALU.
  assert property (@(posedge clk) disable iff (!rst_n)
    (item_en && (command == CMD_READ) && m_last_nxt) |=>
      ((pend_r == PEND_NONE) && (idx_r == '0)))
    else $error("last read byte did not release the NALU");

endmodule

[dv/tb_h264_fu_a_depacketizer.sv]
// Testbench for the H.264 RTP FU-A depacketizer: directed table, then random traffic.
`timescale 1ns / 1ps
module tb_h264_fu_a_depacketizer;
  import h264fua_pkg::*;

  localparam int SINGLE_CAP = PKT_PAYLOAD_BYTES_DEF;
  localparam int REASM_CAP  = NALU_BYTES_DEF;
  localparam int RAND_ITEMS = 1150;

  typedef logic [7:0] byte_q_t [$];

  // One row of the directed table: optional RTP header bytes, then the row's item repeated.
  typedef struct packed {
    logic [3:0] hdr_len;
    logic [4:0] reps;
    cmd_t       cmd;
    logic [7:0] data;
    logic       last;
    logic       typed;
    result_t    want;
  } dir_row_t;

  localparam result_t R_IDLE    = '{ST_OK, 8'h00, 1'b0, 1'b0, 1'b0};
  localparam result_t R_EMPTY   = '{ST_EMPTY, 8'h00, 1'b0, 1'b0, 1'b0};
  localparam result_t R_DROP    = '{ST_DROPPED, 8'h00, 1'b0, 1'b0, 1'b0};
  localparam result_t R_OVERRUN = '{ST_OVERRUN, 8'h00, 1'b0, 1'b0, 1'b1};
  localparam result_t R_SC_ZERO = '{ST_OK, 8'h00, 1'b1, 1'b0, 1'b1};
  localparam result_t R_SC_ONE  = '{ST_OK, 8'h01, 1'b1, 1'b0, 1'b1};

  localparam dir_row_t DIRECTED [30] = '{
    // Nothing stored yet: read and flush find nothing, an unused command does nothing.
    '{4'd0,  5'd1, CMD_READ,   8'h00, 1'b0, 1'b1, R_EMPTY},
    '{4'd0,  5'd1, CMD_FLUSH,  8'hFF, 1'b1, 1'b1, R_EMPTY},
    '{4'd0,  5'd1, CMD_NONE,   8'hFF, 1'b1, 1'b1, R_IDLE},
    // Short packets: one payload byte, then no payload at all.
    '{4'd12, 5'd1, CMD_PACKET, 8'h00, 1'b1, 1'b1, R_DROP},
    '{4'd11, 5'd1, CMD_PACKET, 8'hFF, 1'b1, 1'b1, R_DROP},
    // Single NALU of two bytes, then a packet that overruns it and a refused flush.
    '{4'd12, 5'd1, CMD_PACKET, 8'hFF, 1'b0, 1'b0, R_IDLE},
    '{4'd0,  5'd1, CMD_PACKET, 8'h00, 1'b1, 1'b0, R_IDLE},
    '{4'd0,  5'd1, CMD_PACKET, 8'h55, 1'b0, 1'b1, R_OVERRUN},
    '{4'd0,  5'd1, CMD_PACKET, 8'hAA, 1'b1, 1'b1, R_OVERRUN},
    '{4'd0,  5'd1, CMD_FLUSH,  8'h00, 1'b0, 1'b1, R_OVERRUN},
    // Start code, then the NALU itself.
    '{4'd0,  5'd3, CMD_READ,   8'hFF, 1'b0, 1'b1, R_SC_ZERO},
    '{4'd0,  5'd1, CMD_READ,   8'hFF, 1'b1, 1'b1, R_SC_ONE},
    '{4'd0,  5'd2, CMD_READ,   8'h00, 1'b0, 1'b0, R_IDLE},
    // Continuation fragment with no reassembly open.
    '{4'd12, 5'd1, CMD_PACKET, 8'h7C, 1'b0, 1'b0, R_IDLE},
    '{4'd0,  5'd1, CMD_PACKET, 8'h05, 1'b0, 1'b0, R_IDLE},
    '{4'd0,  5'd1, CMD_PACKET, 8'h11, 1'b1, 1'b0, R_IDLE},
    // Start and end bits together only open the reassembly.
    '{4'd12, 5'd1, CMD_PACKET, 8'hFC, 1'b0, 1'b0, R_IDLE},
    '{4'd0,  5'd1, CMD_PACKET, 8'hC5, 1'b0, 1'b0, R_IDLE},
    '{4'd0,  5'd1, CMD_PACKET, 8'h22, 1'b0, 1'b0, R_IDLE},
    '{4'd0,  5'd1, CMD_PACKET, 8'h33, 1'b1, 1'b0, R_IDLE},
    // End fragment completes it; read it out.
    '{4'd12, 5'd1, CMD_PACKET, 8'h1C, 1'b0, 1'b0, R_IDLE},
    '{4'd0,  5'd1, CMD_PACKET, 8'h45, 1'b0, 1'b0, R_IDLE},
    '{4'd0,  5'd1, CMD_PACKET, 8'h44, 1'b1, 1'b0, R_IDLE},
    '{4'd0,  5'd8, CMD_READ,   8'hFF, 1'b1, 1'b0, R_IDLE},
    // Partial reassembly completed by a flush.
    '{4'd12, 5'd1, CMD_PACKET, 8'h7C, 1'b0, 1'b0, R_IDLE},
    '{4'd0,  5'd1, CMD_PACKET, 8'h85, 1'b0, 1'b0, R_IDLE},
    '{4'd0,  5'd1, CMD_PACKET, 8'hAB, 1'b1, 1'b0, R_IDLE},
    '{4'd0,  5'd1, CMD_FLUSH,  8'h00, 1'b0, 1'b0, R_IDLE},
    '{4'd0,  5'd6, CMD_READ,   8'h00, 1'b0, 1'b0, R_IDLE},
    '{4'd0,  5'd1, CMD_READ,   8'h00, 1'b1, 1'b1, R_EMPTY}
  };

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic [1:0] in_command;
  logic [7:0] in_data_byte;
  logic       in_packet_end;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [2:0] out_status;
  logic [7:0] out_byte;
  logic       out_out_valid;
  logic       out_nalu_last;
  logic       out_nalu_pending;

  // Depacketizer state as the checker sees it.
  logic [15:0] pkt_pos;
  logic [7:0]  ind_byte;
  logic [7:0]  frag_hdr;
  logic [7:0]  single_mem [SINGLE_CAP];
  int          single_len;
  logic [7:0]  reasm_mem [REASM_CAP];
  int          reasm_len;
  pend_src_t   pend;
  int          rd_idx;
  logic        pkt_spoiled;

  result_t depack_results [$];
  bit      idle_en  = 1'b1;
  bit      mix_cmds = 1'b0;
  int      n_items;
  int      n_results;
  int      nalus_read;
  int      mismatch_count;
  int      st_seen [8];

  h264_fu_a_depacketizer uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_command      (in_command),
    .in_data_byte    (in_data_byte),
    .in_packet_end   (in_packet_end),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_byte        (out_byte),
    .out_out_valid   (out_out_valid),
    .out_nalu_last   (out_nalu_last),
    .out_nalu_pending(out_nalu_pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Computes the result of one accepted item and advances the depacketizer state.
  function automatic result_t depacketize(cmd_t c, logic [7:0] d, logic e);
    result_t r;
    logic [15:0] pos;
    int pl;
    int total;
    bit from_single;
    r = R_IDLE;
    case (c)
      CMD_PACKET: begin
        pos = pkt_pos;
        if (pkt_spoiled || pend != PEND_NONE) begin
          pkt_spoiled = 1'b1;
          r.status = ST_OVERRUN;
        end else if (int'(pos) >= RTP_HDR_BYTES) begin
          pl = int'(pos) - RTP_HDR_BYTES;
          if (pl == 0) begin
            ind_byte = d;
            if ((d & TYPE_MASK) != FU_A_TYPE) begin
              single_mem[0] = d;
              single_len = 1;
            end
          end else if ((ind_byte & TYPE_MASK) != FU_A_TYPE) begin
            if (single_len < SINGLE_CAP) begin
              single_mem[single_len] = d;
              single_len++;
            end else begin
              r.status = ST_TRUNC;
            end
          end else if (pl == 1) begin
            frag_hdr = d;
            if (d[S_BIT]) begin
              reasm_mem[0] = (ind_byte & F_NRI_MASK) | (d & TYPE_MASK);
              reasm_len = 1;
            end
          end else if (reasm_len != 0) begin
            if (reasm_len < REASM_CAP) begin
              reasm_mem[reasm_len] = d;
              reasm_len++;
            end else begin
              r.status = ST_TRUNC;
            end
          end
        end
        if (pkt_pos != 16'hFFFF) pkt_pos++;
        // Packet end: drop short payloads, otherwise maybe complete a NALU.
        if (e) begin
          if (!pkt_spoiled) begin
            if (int'(pos) + 1 < RTP_HDR_BYTES + 2) begin
              r.status = ST_DROPPED;
            end else if ((ind_byte & TYPE_MASK) != FU_A_TYPE) begin
              pend = PEND_SINGLE;
              rd_idx = 0;
            end else if (!frag_hdr[S_BIT] && frag_hdr[E_BIT] && reasm_len != 0) begin
              pend = PEND_REASM;
              rd_idx = 0;
            end
          end
          pkt_pos = '0;
          pkt_spoiled = 1'b0;
        end
      end
      CMD_READ: begin
        if (pend == PEND_NONE) begin
          r.status = ST_EMPTY;
        end else begin
          from_single = (pend == PEND_SINGLE);
          total = 4 + (from_single ? single_len : reasm_len);
          if (rd_idx < 4) r.byte_val = ANNEXB_PREFIX[rd_idx];
          else if (from_single) r.byte_val = single_mem[rd_idx - 4];
          else r.byte_val = reasm_mem[rd_idx - 4];
          r.byte_vld = 1'b1;
          if (rd_idx + 1 >= total) begin
            r.nalu_last = 1'b1;
            if (from_single) single_len = 0;
            else reasm_len = 0;
            pend = PEND_NONE;
            rd_idx = 0;
          end else begin
            rd_idx++;
          end
        end
      end
      CMD_FLUSH: begin
        if (pend != PEND_NONE) begin
          r.status = ST_OVERRUN;
        end else if (reasm_len == 0) begin
          r.status = ST_EMPTY;
        end else begin
          pend = PEND_REASM;
          rd_idx = 0;
        end
      end
      default: ;
    endcase
    r.pending = (pend != PEND_NONE);
    return r;
  endfunction

  task automatic flag_mismatch(input string msg);
    mismatch_count++;
    $display("%0t ns: mismatch: %s", $time, msg);
  endtask

  // Drives one item from a falling edge and holds it until the transfer happens.
  task automatic transfer_item(input cmd_t c, input logic [7:0] d, input logic e,
                               input logic typed, input result_t want);
    result_t pred;
    while (idle_en && $urandom_range(99) < 33) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_command    <= c;
    in_data_byte  <= d;
    in_packet_end <= e;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pred = depacketize(c, d, e);
    depack_results.insert(depack_results.size(), typed ? want : pred);
    n_items++;
    @(negedge clk);
  endtask

  task automatic transfer(input cmd_t c, input logic [7:0] d, input logic e);
    transfer_item(c, d, e, 1'b0, R_IDLE);
  endtask

  // Sends a whole RTP packet; random commands may slip in between its bytes.
  task automatic send_packet(input byte_q_t payload);
    int total;
    logic [7:0] b;
    total = RTP_HDR_BYTES + payload.size();
    for (int i = 0; i < total; i++) begin
      if (mix_cmds && $urandom_range(99) < 2)
        transfer(cmd_t'($urandom_range(1, 3)), 8'($urandom), 1'($urandom));
      if (i < RTP_HDR_BYTES) b = 8'($urandom);
      else b = payload[i - RTP_HDR_BYTES];
      transfer(CMD_PACKET, b, i == total - 1);
    end
  endtask

  function automatic logic [7:0] non_fua_byte();
    logic [7:0] b;
    b = 8'($urandom);
    if ((b & TYPE_MASK) == FU_A_TYPE) b[4:0] = 5'($urandom_range(0, 27));
    return b;
  endfunction

  task automatic send_single_nalu();
    byte_q_t pay;
    int len;
    int roll;
    roll = $urandom_range(99);
    if (roll < 8) len = $urandom_range(0, 1);
    else if (roll < 11) len = $urandom_range(100, 400);
    else len = $urandom_range(2, 40);
    if (len > 0) pay.insert(pay.size(), non_fua_byte());
    while (pay.size() < len) pay.insert(pay.size(), 8'($urandom));
    send_packet(pay);
  endtask

  task automatic send_fragment(input logic s, input logic e);
    byte_q_t pay;
    pay.insert(pay.size(), {3'($urandom), 5'(FU_A_TYPE)});
    pay.insert(pay.size(), {s, e, 6'($urandom)});
    repeat ($urandom_range(0, 30)) pay.insert(pay.size(), 8'($urandom));
    send_packet(pay);
  endtask

  // A fragmented NALU, sometimes with a stray fragment, a combined start/end or a flush.
  task automatic send_fua_nalu();
    int v;
    v = $urandom_range(99);
    if (v < 8) send_fragment(1'b0, 1'($urandom));
    send_fragment(1'b1, v >= 8 && v < 18);
    repeat ($urandom_range(0, 3)) send_fragment(1'b0, 1'b0);
    if (v >= 18 && v < 28) transfer(CMD_FLUSH, 8'($urandom), 1'($urandom));
    else send_fragment(1'b0, 1'b1);
  endtask

  task automatic drain_nalu();
    while (pend != PEND_NONE) transfer(CMD_READ, 8'($urandom), 1'($urandom));
  endtask

  // Compare each result transfer with the oldest prediction.
  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_valid && !out_stall) begin
      n_results++;
      st_seen[out_status]++;
      if (out_nalu_last) nalus_read++;
      if (depack_results.size() == 0) begin
        flag_mismatch($sformatf("result %0d arrived with nothing predicted", n_results));
      end else begin
        want = depack_results.pop_front();
        if (out_status !== want.status)
          flag_mismatch($sformatf("result %0d status %0d, predicted %0d",
                                  n_results, out_status, want.status));
        if (out_byte !== want.byte_val)
          flag_mismatch($sformatf("result %0d byte %02h, predicted %02h",
                                  n_results, out_byte, want.byte_val));
        if (out_out_valid !== want.byte_vld)
          flag_mismatch($sformatf("result %0d byte valid %0b, predicted %0b",
                                  n_results, out_out_valid, want.byte_vld));
        if (out_nalu_last !== want.nalu_last)
          flag_mismatch($sformatf("result %0d nalu_last %0b, predicted %0b",
                                  n_results, out_nalu_last, want.nalu_last));
        if (out_nalu_pending !== want.pending)
          flag_mismatch($sformatf("result %0d nalu_pending %0b, predicted %0b",
                                  n_results, out_nalu_pending, want.pending));
      end
    end
  end

  // Receiver back-pressure.
  always @(negedge clk) begin
    out_stall <= idle_en && ($urandom_range(99) < 33);
  end

  initial begin
    #20_000_000;
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    int rand_base;
    int progress;
    int roll;
    bit paused;
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_command    = CMD_NONE;
    in_data_byte  = 8'h00;
    in_packet_end = 1'b0;
    pkt_pos       = '0;
    ind_byte      = 8'h00;
    frag_hdr      = 8'h00;
    single_len    = 0;
    reasm_len     = 0;
    pend          = PEND_NONE;
    rd_idx        = 0;
    pkt_spoiled   = 1'b0;
    paused        = 1'b0;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed table.
    foreach (DIRECTED[i]) begin
      repeat (DIRECTED[i].hdr_len) transfer(CMD_PACKET, 8'($urandom), 1'b0);
      repeat (DIRECTED[i].reps)
        transfer_item(DIRECTED[i].cmd, DIRECTED[i].data, DIRECTED[i].last,
                      DIRECTED[i].typed, DIRECTED[i].want);
    end

    // Random traffic: mostly well-formed packets, some noise and broken framing.
    mix_cmds  = 1'b1;
    rand_base = n_items;
    progress  = 0;
    while (progress < RAND_ITEMS) begin
      roll = $urandom_range(99);
      if (roll < 30) begin
        send_single_nalu();
      end else if (roll < 65) begin
        send_fua_nalu();
      end else if (roll < 75) begin
        transfer(CMD_READ, 8'($urandom), 1'($urandom));
      end else if (roll < 82) begin
        transfer(CMD_FLUSH, 8'($urandom), 1'($urandom));
      end else if (roll < 88) begin
        transfer(CMD_NONE, 8'($urandom), 1'($urandom));
      end else begin
        repeat ($urandom_range(1, 16))
          transfer(cmd_t'($urandom_range(0, 3)), 8'($urandom), $urandom_range(7) == 0);
        if ($urandom_range(1)) transfer(CMD_PACKET, 8'($urandom), 1'b1);
      end
      if (pend != PEND_NONE && $urandom_range(99) < 75) drain_nalu();
      progress = n_items - rand_base;
      idle_en  = !(progress >= 400 && progress < 700);
      // Let the block run completely dry once before carrying on.
      if (!paused && progress >= 900) begin
        paused = 1'b1;
        in_valid <= 1'b0;
        wait (depack_results.size() == 0);
        @(negedge clk);
      end
    end
    idle_en = 1'b1;
    in_valid <= 1'b0;

    wait (depack_results.size() == 0);
    repeat (10) @(posedge clk);
    $display("Run covered %0d transfers in, %0d results out, %0d NALUs read back.",
             n_items, n_results, nalus_read);
    $display("Statuses seen: ok %0d, overrun %0d, empty %0d, dropped %0d, truncated %0d.",
             st_seen[ST_OK], st_seen[ST_OVERRUN], st_seen[ST_EMPTY],
             st_seen[ST_DROPPED], st_seen[ST_TRUNC]);
    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
